// ===== design/pvs_pkg.sv =====
package pvs_pkg;

   localparam int SAL_FRAC_BITS = 10;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_R1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TSTD = 3'd4;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_SUPPLY = 2'd1;
   localparam logic [1:0] STAT_COND = 2'd2;

   localparam logic signed [14:0] TEMP_MIN = -15'sd1280;
   localparam logic signed [14:0] TEMP_MAX = 15'sd12800;
   localparam logic signed [15:0] TEMP_REF = 16'sd3840;

   localparam logic signed [63:0] P40 = 64'sd1099511627776;
   localparam logic signed [63:0] ONE24 = 64'sd16777216;
   localparam logic [63:0] RATIO_CAP = 64'd1 << 28;
   localparam logic [63:0] COND_SCALE = 64'd16000000;

   localparam logic signed [63:0] RT_C0 = 64'sd6766097 * P40 / 64'sd10000000;
   localparam logic signed [63:0] RT_C1 = 64'sd200564 * P40 / 64'sd10000000;
   localparam logic signed [63:0] RT_C2 = 64'sd1104259 * P40 / 64'sd10000000000;
   localparam logic signed [63:0] RT_C3 = -(64'sd69698 * P40 / 64'sd100000000000);
   localparam logic signed [63:0] RT_C4 = 64'sd10031 * P40 / 64'sd10000000000000;

   localparam logic signed [63:0] A0 = 64'sd80 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] A1 = -64'sd1692 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] A2 = 64'sd253851 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] A3 = 64'sd140941 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] A4 = -64'sd70261 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] A5 = 64'sd27081 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] B0 = 64'sd5 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] B1 = -64'sd56 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] B2 = -64'sd66 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] B3 = -64'sd375 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] B4 = 64'sd636 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] B5 = -64'sd144 * ONE24 / 64'sd10000;
   localparam logic signed [63:0] COEF_K = 64'sd162 * ONE24 / 64'sd10000;

   typedef struct packed {
      logic [19:0] r1;
      logic [19:0] gap;
      logic [19:0] area;
      logic [23:0] std_cond;
      logic signed [14:0] t_std;
   } cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic [15:0] diff;
      logic [15:0] vp;
      logic signed [14:0] ts;
   } item_type;

   typedef enum logic [4:0] {
      S_IDLE, S_NUM, S_P2, S_DEN, S_COND, S_RATIO, S_RATIO2, S_RT_START, S_RT_STEP,
      S_RTC, S_SQ, S_PSTART, S_PINIT, S_POLY, S_K, S_FDEN, S_F, S_S, S_DONE,
      S_MUL, S_DIV, S_SQRT
   } state_type;

   function automatic logic signed [14:0] clamp_temp(input logic signed [14:0] t);
      logic signed [14:0] r;
      r = t;
      if (t < TEMP_MIN) r = TEMP_MIN;
      if (t > TEMP_MAX) r = TEMP_MAX;
      return r;
   endfunction

   function automatic logic signed [63:0] rt_coef(input logic [2:0] i);
      logic signed [63:0] c;
      case (i)
         3'd0: c = RT_C0;
         3'd1: c = RT_C1;
         3'd2: c = RT_C2;
         3'd3: c = RT_C3;
         3'd4: c = RT_C4;
         default: c = 64'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [63:0] poly_coef(input logic sel_b, input logic [2:0] i);
      logic signed [63:0] c;
      case (i)
         3'd0: c = sel_b ? B0 : A0;
         3'd1: c = sel_b ? B1 : A1;
         3'd2: c = sel_b ? B2 : A2;
         3'd3: c = sel_b ? B3 : A3;
         3'd4: c = sel_b ? B4 : A4;
         3'd5: c = sel_b ? B5 : A5;
         default: c = 64'sd0;
      endcase
      return c;
   endfunction

endpackage

// ===== design/pvs_front.sv =====
module pvs_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_supply_voltage,
   input  logic [15:0]        req_probe_voltage,
   input  logic signed [14:0] req_sample_temp_q8,
   input  pvs_pkg::cfg_type   cfg,
   output logic               push,
   input  logic               q_ready,
   output pvs_pkg::item_type  item
);

   always_comb begin
      req_ready = q_ready;
      push = req_valid & q_ready;
      item.diff = req_supply_voltage - req_probe_voltage;
      item.vp = req_probe_voltage;
      item.ts = pvs_pkg::clamp_temp(req_sample_temp_q8);
      if (req_supply_voltage <= req_probe_voltage) begin
         item.status = pvs_pkg::STAT_SUPPLY;
      end else if (req_probe_voltage == 16'd0 || cfg.r1 == 20'd0 || cfg.area == 20'd0 ||
                   cfg.std_cond == 24'd0) begin
         item.status = pvs_pkg::STAT_COND;
      end else begin
         item.status = pvs_pkg::STAT_OK;
      end
   end

endmodule

// ===== design/pvs_queue.sv =====
module pvs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pvs_pkg::item_type push_item,
   output logic              in_ready,
   input  logic              pop,
   output logic              out_valid,
   output pvs_pkg::item_type out_item
);

   pvs_pkg::item_type mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      in_ready = count_ff != 2'd2;
      out_valid = count_ff != 2'd0;
      out_item = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/pvs_back.sv =====
module pvs_back (
   input  logic              clock,
   input  logic              reset,
   input  pvs_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  pvs_pkg::item_type q_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_salinity_q10,
   output logic [1:0]        rsp_status
);

   pvs_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [63:0] ma_ff, ma_in, mp_ff, mp_in;
   logic [31:0] mb_ff, mb_in;
   logic [63:0] dn_ff, dn_in, dd_ff, dd_in, dr_ff, dr_in, dq_ff, dq_in;
   logic [63:0] num_ff, num_in, ratio_ff, ratio_in;
   logic [31:0] rt_std_ff, rt_std_in, rt_smp_ff, rt_smp_in, x_ff, x_in;
   logic signed [63:0] acc_ff, acc_in, pa_ff, pa_in, pb_ff, pb_in;
   logic [2:0] idx_ff, idx_in;
   logic neg_ff, neg_in, sel_ff, sel_in;
   pvs_pkg::item_type item_ff, item_in;
   logic [15:0] sal_ff, sal_in;
   logic [1:0] stat_ff, stat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_sal_ff, rsp_sal_in;
   logic [1:0] rsp_stat_ff, rsp_stat_in;

   logic signed [14:0] t_cur;
   logic [15:0] t_abs;
   logic signed [15:0] dt_q8;
   logic dt_neg;
   logic [15:0] dt_abs;
   logic signed [63:0] pv8, pv24, accn, cval, rt_res, s_val;
   logic [64:0] rs;
   logic [63:0] sq_t, rtc, u_val;

   always_comb begin
      t_cur = sel_ff ? item_ff.ts : pvs_pkg::clamp_temp(cfg.t_std);
      t_abs = t_cur[14] ? 16'(-$signed({t_cur[14], t_cur})) : {1'b0, t_cur};
      dt_q8 = $signed({item_ff.ts[14], item_ff.ts}) - pvs_pkg::TEMP_REF;
      dt_neg = dt_q8[15];
      dt_abs = dt_neg ? 16'(-dt_q8) : dt_q8;
      pv8 = $signed(mp_ff >> 8);
      pv24 = $signed(mp_ff >> 24);
      rs = {dr_ff, dn_ff[63]};
      sq_t = dq_ff + dd_ff;
      rtc = (dq_ff > pvs_pkg::RATIO_CAP) ? pvs_pkg::RATIO_CAP : dq_ff;
      cval = 64'sd0;
      accn = 64'sd0;
      rt_res = 64'sd0;
      s_val = 64'sd0;
      u_val = 64'd0;

      state_in = state_ff;
      ret_in = ret_ff;
      cnt_in = cnt_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      mp_in = mp_ff;
      dn_in = dn_ff;
      dd_in = dd_ff;
      dr_in = dr_ff;
      dq_in = dq_ff;
      num_in = num_ff;
      ratio_in = ratio_ff;
      rt_std_in = rt_std_ff;
      rt_smp_in = rt_smp_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      idx_in = idx_ff;
      neg_in = neg_ff;
      sel_in = sel_ff;
      item_in = item_ff;
      sal_in = sal_ff;
      stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_sal_in = rsp_sal_ff;
      rsp_stat_in = rsp_stat_ff;
      pop = 1'b0;

      case (state_ff)
         pvs_pkg::S_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               item_in = q_item;
               if (q_item.status != pvs_pkg::STAT_OK) begin
                  sal_in = 16'd0;
                  stat_in = q_item.status;
                  state_in = pvs_pkg::S_DONE;
               end else begin
                  ma_in = pvs_pkg::COND_SCALE;
                  mb_in = {12'd0, cfg.gap};
                  mp_in = 64'd0;
                  cnt_in = 6'd0;
                  ret_in = pvs_pkg::S_NUM;
                  state_in = pvs_pkg::S_MUL;
               end
            end
         end
         pvs_pkg::S_NUM: begin
            ma_in = mp_ff;
            mb_in = {16'd0, item_ff.diff};
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_P2;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_P2: begin
            num_in = mp_ff;
            ma_in = {44'd0, cfg.r1};
            mb_in = {16'd0, item_ff.vp};
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_DEN;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_DEN: begin
            ma_in = mp_ff;
            mb_in = {12'd0, cfg.area};
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_COND;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_COND: begin
            dn_in = num_ff;
            dd_in = mp_ff;
            dr_in = 64'd0;
            dq_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_RATIO;
            state_in = pvs_pkg::S_DIV;
         end
         pvs_pkg::S_RATIO: begin
            if (dq_ff >= {32'd0, cfg.std_cond, 8'd0}) begin
               ratio_in = pvs_pkg::RATIO_CAP;
               sel_in = 1'b0;
               state_in = pvs_pkg::S_RT_START;
            end else begin
               dn_in = dq_ff << 20;
               dd_in = {40'd0, cfg.std_cond};
               dr_in = 64'd0;
               dq_in = 64'd0;
               cnt_in = 6'd0;
               ret_in = pvs_pkg::S_RATIO2;
               state_in = pvs_pkg::S_DIV;
            end
         end
         pvs_pkg::S_RATIO2: begin
            ratio_in = dq_ff;
            sel_in = 1'b0;
            state_in = pvs_pkg::S_RT_START;
         end
         pvs_pkg::S_RT_START: begin
            acc_in = pvs_pkg::RT_C4;
            idx_in = 3'd3;
            ma_in = pvs_pkg::RT_C4[63] ? 64'(-pvs_pkg::RT_C4) : pvs_pkg::RT_C4;
            mb_in = {16'd0, t_abs};
            neg_in = pvs_pkg::RT_C4[63] ^ t_cur[14];
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_RT_STEP;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_RT_STEP: begin
            accn = pvs_pkg::rt_coef(idx_ff) + (neg_ff ? -pv8 : pv8);
            if (idx_ff == 3'd0) begin
               rt_res = accn >>> 16;
               if (rt_res < 64'sd1) rt_res = 64'sd1;
               if (!sel_ff) begin
                  rt_std_in = rt_res[31:0];
                  sel_in = 1'b1;
                  state_in = pvs_pkg::S_RT_START;
               end else begin
                  rt_smp_in = rt_res[31:0];
                  ma_in = ratio_ff;
                  mb_in = rt_std_ff;
                  mp_in = 64'd0;
                  cnt_in = 6'd0;
                  ret_in = pvs_pkg::S_RTC;
                  state_in = pvs_pkg::S_MUL;
               end
            end else begin
               acc_in = accn;
               idx_in = idx_ff - 3'd1;
               ma_in = accn[63] ? 64'(-accn) : accn;
               mb_in = {16'd0, t_abs};
               neg_in = accn[63] ^ t_cur[14];
               mp_in = 64'd0;
               cnt_in = 6'd0;
               ret_in = pvs_pkg::S_RT_STEP;
               state_in = pvs_pkg::S_MUL;
            end
         end
         pvs_pkg::S_RTC: begin
            dn_in = mp_ff;
            dd_in = {32'd0, rt_smp_ff};
            dr_in = 64'd0;
            dq_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_SQ;
            state_in = pvs_pkg::S_DIV;
         end
         pvs_pkg::S_SQ: begin
            if (rtc == 64'd0) begin
               sal_in = 16'd0;
               stat_in = pvs_pkg::STAT_OK;
               state_in = pvs_pkg::S_DONE;
            end else begin
               dn_in = rtc << 24;
               dq_in = 64'd0;
               dd_in = 64'd1 << 52;
               cnt_in = 6'd0;
               ret_in = pvs_pkg::S_PSTART;
               state_in = pvs_pkg::S_SQRT;
            end
         end
         pvs_pkg::S_PSTART: begin
            x_in = dq_ff[31:0];
            sel_in = 1'b0;
            state_in = pvs_pkg::S_PINIT;
         end
         pvs_pkg::S_PINIT: begin
            cval = pvs_pkg::poly_coef(sel_ff, 3'd5);
            acc_in = cval;
            idx_in = 3'd4;
            ma_in = cval[63] ? 64'(-cval) : cval;
            mb_in = x_ff;
            neg_in = cval[63];
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_POLY;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_POLY: begin
            accn = pvs_pkg::poly_coef(sel_ff, idx_ff) + (neg_ff ? -pv24 : pv24);
            if (idx_ff == 3'd0) begin
               if (!sel_ff) begin
                  pa_in = accn;
                  sel_in = 1'b1;
                  state_in = pvs_pkg::S_PINIT;
               end else begin
                  pb_in = accn;
                  state_in = pvs_pkg::S_K;
               end
            end else begin
               acc_in = accn;
               idx_in = idx_ff - 3'd1;
               ma_in = accn[63] ? 64'(-accn) : accn;
               mb_in = x_ff;
               neg_in = accn[63];
               mp_in = 64'd0;
               cnt_in = 6'd0;
               ret_in = pvs_pkg::S_POLY;
               state_in = pvs_pkg::S_MUL;
            end
         end
         pvs_pkg::S_K: begin
            ma_in = pvs_pkg::COEF_K;
            mb_in = {dt_abs, 16'd0};
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_FDEN;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_FDEN: begin
            dn_in = {8'd0, dt_abs, 40'd0};
            dd_in = pvs_pkg::ONE24 + (dt_neg ? -pv24 : pv24);
            dr_in = 64'd0;
            dq_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_F;
            state_in = pvs_pkg::S_DIV;
         end
         pvs_pkg::S_F: begin
            ma_in = pb_ff[63] ? 64'(-pb_ff) : pb_ff;
            mb_in = dq_ff[31:0];
            neg_in = pb_ff[63] ^ dt_neg;
            mp_in = 64'd0;
            cnt_in = 6'd0;
            ret_in = pvs_pkg::S_S;
            state_in = pvs_pkg::S_MUL;
         end
         pvs_pkg::S_S: begin
            s_val = pa_ff + (neg_ff ? -pv24 : pv24);
            u_val = 64'(s_val) >> (24 - pvs_pkg::SAL_FRAC_BITS);
            if (s_val <= 64'sd0) begin
               sal_in = 16'd0;
            end else if (u_val > 64'd65535) begin
               sal_in = 16'hffff;
            end else begin
               sal_in = u_val[15:0];
            end
            stat_in = pvs_pkg::STAT_OK;
            state_in = pvs_pkg::S_DONE;
         end
         pvs_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sal_in = sal_ff;
               rsp_stat_in = stat_ff;
               state_in = pvs_pkg::S_IDLE;
            end
         end
         pvs_pkg::S_MUL: begin
            if (mb_ff[0]) mp_in = mp_ff + ma_ff;
            ma_in = ma_ff << 1;
            mb_in = mb_ff >> 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) state_in = ret_ff;
         end
         pvs_pkg::S_DIV: begin
            if (rs >= {1'b0, dd_ff}) begin
               dr_in = 64'(rs - {1'b0, dd_ff});
               dq_in = {dq_ff[62:0], 1'b1};
            end else begin
               dr_in = rs[63:0];
               dq_in = {dq_ff[62:0], 1'b0};
            end
            dn_in = dn_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ret_ff;
         end
         pvs_pkg::S_SQRT: begin
            if (dn_ff >= sq_t) begin
               dn_in = dn_ff - sq_t;
               dq_in = (dq_ff >> 1) + dd_ff;
            end else begin
               dq_in = dq_ff >> 1;
            end
            dd_in = dd_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd26) state_in = ret_ff;
         end
         default: begin
            state_in = pvs_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_salinity_q10 = rsp_sal_ff;
   assign rsp_status = rsp_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvs_pkg::S_IDLE;
         ret_ff <= pvs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      mp_ff <= mp_in;
      dn_ff <= dn_in;
      dd_ff <= dd_in;
      dr_ff <= dr_in;
      dq_ff <= dq_in;
      num_ff <= num_in;
      ratio_ff <= ratio_in;
      rt_std_ff <= rt_std_in;
      rt_smp_ff <= rt_smp_in;
      x_ff <= x_in;
      acc_ff <= acc_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
      sel_ff <= sel_in;
      item_ff <= item_in;
      sal_ff <= sal_in;
      stat_ff <= stat_in;
      rsp_sal_ff <= rsp_sal_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule

// ===== design/probe_voltage_to_salinity_unit.sv =====
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    supply_voltage, probe_voltage, sample_temp_q8
// rsp      out        rsp_valid/rsp_ready    salinity_q10, status
// csr      in         csr_write              csr_index, csr_wdata
// a normal beat runs in the back end as 25 bit-serial multiplies, 4 restoring divides,
// a square root and the sequencing states; a saturated ratio skips one divide and one
// state, and a zero corrected ratio goes to S_DONE without the square root
// a beat flagged by the front end goes from S_IDLE straight to S_DONE
// req is taken while the 2-entry queue has room; rsp holds in its output register
// synchronous active-high reset empties the queue and loads the csr reset values
module probe_voltage_to_salinity_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [15:0]                    req_supply_voltage,
   input  logic [15:0]                    req_probe_voltage,
   input  logic signed [14:0]             req_sample_temp_q8,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [15:0]                    rsp_salinity_q10,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_write,
   input  logic [pvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pvs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pvs_pkg::cfg_type cfg_ff, cfg_in;
   pvs_pkg::item_type f_item, q_item;
   logic push, q_ready, q_valid, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            pvs_pkg::CSR_R1: cfg_in.r1 = csr_wdata[19:0];
            pvs_pkg::CSR_GAP: cfg_in.gap = csr_wdata[19:0];
            pvs_pkg::CSR_AREA: cfg_in.area = csr_wdata[19:0];
            pvs_pkg::CSR_STD: cfg_in.std_cond = csr_wdata;
            pvs_pkg::CSR_TSTD: cfg_in.t_std = csr_wdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.r1 <= 20'd10000;
         cfg_ff.gap <= 20'd10000;
         cfg_ff.area <= 20'd400;
         cfg_ff.std_cond <= 24'd4291400;
         cfg_ff.t_std <= 15'sd3840;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pvs_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_supply_voltage (req_supply_voltage),
      .req_probe_voltage  (req_probe_voltage),
      .req_sample_temp_q8 (req_sample_temp_q8),
      .cfg                (cfg_ff),
      .push               (push),
      .q_ready            (q_ready),
      .item               (f_item)
   );

   pvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (f_item),
      .in_ready  (q_ready),
      .pop       (pop),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   pvs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_salinity_q10 (rsp_salinity_q10),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== tb/salinity_checker.sv =====
module salinity_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [15:0]                    req_supply_voltage,
   input  logic [15:0]                    req_probe_voltage,
   input  logic signed [14:0]             req_sample_temp_q8,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [15:0]                    rsp_salinity_q10,
   input  logic [1:0]                     rsp_status,
   input  logic                           csr_write,
   input  logic [pvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pvs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] salinity;
      logic [1:0]  status;
   } reading_type;

   logic [19:0]        r1_ohms;
   logic [19:0]        gap_um;
   logic [19:0]        area_mm2;
   logic [23:0]        std_cond;
   logic signed [14:0] std_temp;

   reading_type expected_readings[$];

   assign outstanding = expected_readings.size();

   function automatic longint scaled_mul(longint a, longint b, int sh);
      longint unsigned ua, ub, p;
      ua = (a < 0) ? longint'(0) - a : a;
      ub = (b < 0) ? longint'(0) - b : b;
      p = (ua * ub) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic longint clamped_temp(logic signed [14:0] t);
      longint v;
      v = t;
      if (v < pvs_pkg::TEMP_MIN) v = pvs_pkg::TEMP_MIN;
      if (v > pvs_pkg::TEMP_MAX) v = pvs_pkg::TEMP_MAX;
      return v;
   endfunction

   function automatic longint temp_ratio_q24(longint t);
      longint acc;
      acc = pvs_pkg::RT_C4;
      acc = pvs_pkg::RT_C3 + scaled_mul(acc, t, 8);
      acc = pvs_pkg::RT_C2 + scaled_mul(acc, t, 8);
      acc = pvs_pkg::RT_C1 + scaled_mul(acc, t, 8);
      acc = pvs_pkg::RT_C0 + scaled_mul(acc, t, 8);
      acc = acc / 65536;
      return (acc < 1) ? 1 : acc;
   endfunction

   function automatic longint poly_in_root(logic sel_b, longint x);
      longint acc;
      longint c[6];
      if (sel_b) c = '{pvs_pkg::B0, pvs_pkg::B1, pvs_pkg::B2, pvs_pkg::B3, pvs_pkg::B4,
                       pvs_pkg::B5};
      else c = '{pvs_pkg::A0, pvs_pkg::A1, pvs_pkg::A2, pvs_pkg::A3, pvs_pkg::A4,
                 pvs_pkg::A5};
      acc = c[5];
      for (int i = 4; i >= 0; i--) acc = c[i] + scaled_mul(acc, x, 24);
      return acc;
   endfunction

   function automatic reading_type predict_salinity(logic [15:0] vs, logic [15:0] vp,
                                                    logic signed [14:0] t_raw);
      reading_type res;
      longint unsigned num, den, cond, ratio, rtc, u;
      longint ts, x, pa, pb, dt, fden, f, s;
      res.salinity = 0;
      res.status = pvs_pkg::STAT_OK;
      ts = clamped_temp(t_raw);
      if (vs <= vp) begin
         res.status = pvs_pkg::STAT_SUPPLY;
         return res;
      end
      if (vp == 0 || r1_ohms == 0 || area_mm2 == 0 || std_cond == 0) begin
         res.status = pvs_pkg::STAT_COND;
         return res;
      end
      num = 64'd16000000 * 64'(gap_um) * 64'(vs - vp);
      den = 64'(r1_ohms) * 64'(vp) * 64'(area_mm2);
      cond = num / den;
      if (cond >= 64'(std_cond) * 256) ratio = pvs_pkg::RATIO_CAP;
      else ratio = (cond << 20) / 64'(std_cond);
      rtc = ratio * longint'(temp_ratio_q24(clamped_temp(std_temp)))
            / longint'(temp_ratio_q24(ts));
      if (rtc > pvs_pkg::RATIO_CAP) rtc = pvs_pkg::RATIO_CAP;
      if (rtc == 0) return res;
      x = int_sqrt(rtc << 24);
      pa = poly_in_root(1'b0, x);
      pb = poly_in_root(1'b1, x);
      dt = (ts - 3840) * 65536;
      fden = pvs_pkg::ONE24 + scaled_mul(pvs_pkg::COEF_K, dt, 24);
      f = dt * pvs_pkg::ONE24 / fden;
      s = pa + scaled_mul(f, pb, 24);
      if (s > 0) begin
         u = longint'(s) >> (24 - pvs_pkg::SAL_FRAC_BITS);
         res.salinity = (u > 65535) ? 16'hFFFF : u[15:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      int errs;
      errs = 0;
      if (reset) begin
         r1_ohms <= 20'd10000;
         gap_um <= 20'd10000;
         area_mm2 <= 20'd400;
         std_cond <= 24'd4291400;
         std_temp <= 15'sd3840;
         expected_readings.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               pvs_pkg::CSR_R1:   r1_ohms <= csr_wdata[19:0];
               pvs_pkg::CSR_GAP:  gap_um <= csr_wdata[19:0];
               pvs_pkg::CSR_AREA: area_mm2 <= csr_wdata[19:0];
               pvs_pkg::CSR_STD:  std_cond <= csr_wdata[23:0];
               pvs_pkg::CSR_TSTD: std_temp <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_readings.push_back(predict_salinity(req_supply_voltage,
               req_probe_voltage, req_sample_temp_q8));
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected beat: salinity_q10 %0d status %0d",
                      rsp_salinity_q10, rsp_status);
               errs++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_salinity_q10 !== want.salinity) begin
                  $error("salinity_q10 expected %0d actual %0d", want.salinity,
                         rsp_salinity_q10);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end
endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CYCLE_LIMIT = 12000000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [15:0]                    req_supply_voltage = '0;
   logic [15:0]                    req_probe_voltage = '0;
   logic signed [14:0]             req_sample_temp_q8 = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [15:0]                    rsp_salinity_q10;
   logic [1:0]                     rsp_status;
   logic                           csr_write = 1'b0;
   logic [pvs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pvs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                             fail_count;
   int                             outstanding;
   longint                         cycles = 0;
   bit                             no_gaps;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   probe_voltage_to_salinity_unit dut (.*);
   salinity_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin
      int beats;
      int hold;
      beats = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats == 200) hold = 6000;
         else if ((beats / 100) % 4 == 1) hold = 0;
         else hold = $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
      end
   end

   task automatic send_beat(logic [15:0] vs, logic [15:0] vp, logic signed [14:0] t);
      int gap;
      req_valid <= 1'b1;
      req_supply_voltage <= vs;
      req_probe_voltage <= vp;
      req_sample_temp_q8 <= t;
      do @(posedge clock); while (!req_ready);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic load_regs(logic [23:0] r1, logic [23:0] gap, logic [23:0] area,
                            logic [23:0] std_c, logic [23:0] t_std);
      logic [23:0] vals[5];
      vals = '{r1, gap, area, std_c, t_std};
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[pvs_pkg::CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_beat;
      logic [15:0] vs, vp;
      logic signed [14:0] t;
      int mode;
      vs = 16'($urandom_range(0, 65535));
      mode = $urandom_range(0, 99);
      if (mode < 70) vp = 16'(vs / $urandom_range(2, 2000) + $urandom_range(0, 3));
      else if (mode < 85) vp = 16'($urandom_range(0, 65535));
      else if (mode < 93) vp = 16'(vs + $urandom_range(0, 2));
      else vp = 0;
      mode = $urandom_range(0, 9);
      if (mode < 8) t = 15'($urandom_range(0, 14080) - 1280);
      else t = 15'($urandom_range(0, 32767));
      send_beat(vs, vp, t);
   endtask

   initial begin
      int counts[7] = '{190, 190, 190, 190, 160, 30, 180};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      no_gaps = 0;
      send_beat(16'd5000, 16'd5000, 15'sd3840);
      send_beat(16'd0, 16'd0, 15'sd0);
      send_beat(16'd0, 16'hFFFF, 15'sd0);
      send_beat(16'hFFFF, 16'd0, 15'sd3840);
      send_beat(16'hFFFF, 16'd1, 15'sd3840);
      send_beat(16'hFFFF, 16'hFFFE, 15'sd3840);
      send_beat(16'd54000, 16'd500, 15'sd3840);
      send_beat(16'd54000, 16'd500, -15'sd1280);
      send_beat(16'd54000, 16'd500, 15'sd12800);
      send_beat(16'd54000, 16'd500, -15'sd16384);
      send_beat(16'd54000, 16'd500, 15'sd16383);
      send_beat(16'd54000, 16'd500, -15'sd1281);
      send_beat(16'd54000, 16'd500, 15'sd12801);
      send_beat(16'd30000, 16'd280, 15'sd5120);
      send_beat(16'd2, 16'd1, 15'sd0);
      send_beat(16'd40000, 16'd20000, 15'sd2000);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: load_regs(24'd10000, 24'd10000, 24'd400, 24'd4291400, 24'd3840);
            1: load_regs(24'd1, 24'd1000000, 24'd1, 24'd1, 24'h7FFB00);
            2: load_regs(24'd1000000, 24'd1, 24'd1000000, 24'd10000000, 24'd12800);
            3: load_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
            4: load_regs(24'd20000, 24'd0, 24'd400, 24'd4291400, 24'h004000);
            5: load_regs(24'd0, 24'd10000, 24'd0, 24'd0, 24'd3840);
            default: load_regs(24'($urandom_range(1000, 100000)),
                               24'($urandom_range(1000, 50000)),
                               24'($urandom_range(50, 2000)),
                               24'($urandom_range(1000000, 6000000)),
                               24'($urandom_range(0, 14080) - 1280));
         endcase
         for (int n = 0; n < counts[ph]; n++) begin
            no_gaps = ((n / 40) % 3 == 2);
            if (ph == 0 && n == 100) drain();
            random_beat();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ===== probe_voltage_to_salinity_unit.f =====
design/pvs_pkg.sv
design/pvs_front.sv
design/pvs_queue.sv
design/pvs_back.sv
design/probe_voltage_to_salinity_unit.sv
tb/salinity_checker.sv
tb/testbench.sv
